>>> rtl/core/fpd_pkg.sv
`timescale 1ns / 1ps

package fpd_pkg;

    // Register field widths
    localparam int unsigned CLK_W   = 29;
    localparam int unsigned FREQ_W  = 28;
    localparam int unsigned MILLI_W = 11;
    localparam int unsigned CFG_W   = 29;
    localparam int unsigned INDEX_W = 2;

    // Result widths
    localparam int unsigned WHOLE_W  = 7;
    localparam int unsigned PERIOD_W = 32;

    // clock_hz * 1000 and freq_hz * 2000 both fit in 39 bits
    localparam int unsigned CLK_PROD_W  = 39;
    localparam int unsigned FREQ_PROD_W = 39;
    // positive divisor is below 2^40
    localparam int unsigned DEN_W = 40;

    localparam int unsigned CLK_SCALE  = 1000;
    localparam int unsigned FREQ_SCALE = 2000;

    localparam int unsigned DELAY_CYCLES        = 2;
    localparam int unsigned DEF_FRACTION_BITS   = 24;

    localparam logic [PERIOD_W-1:0] I32_MAX = 32'h7FFF_FFFF;
    localparam logic [WHOLE_W-1:0]  WHOLE_MAX = 7'd127;

    typedef enum logic [INDEX_W-1:0] {
        REG_CLOCK_HZ     = 2'd0,
        REG_FREQ_HZ      = 2'd1,
        REG_FREQ_MILLIHZ = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_LOAD,
        ST_DIV,
        ST_CALC
    } state_t;

endpackage

>>> rtl/core/fpd_serial_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first.
module fpd_serial_div #(
    parameter int unsigned NUM_W = fpd_pkg::CLK_PROD_W + fpd_pkg::DEF_FRACTION_BITS,
    parameter int unsigned DEN_W = fpd_pkg::DEN_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int unsigned CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] shf_reg, shf_next;

    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, shf_reg[NUM_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        shf_next  = shf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            den_next  = den;
            shf_next  = num;
        end
        else if (busy_reg)
        begin
            // shift one numerator bit in, subtract when it fits
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            shf_next = {shf_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        shf_reg <= shf_next;
    end

    assign quo  = shf_reg;
    assign done = done_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

>>> rtl/core/fractional_period_divider.sv
`timescale 1ns / 1ps

// Fractional half-period generator. Each transfer on the input channel yields one
// result: the whole clock-cycle count of the next half-period, clamped to 0..127
// with out_of_range set when clamped, while an error accumulator carries the
// fraction from request to request (clear_error zeroes it first). The half-period
// round(clock_hz * 2^FRACTION_BITS * 1000 / (2000*freq_hz + 2*freq_millihz)) minus
// DELAY_Q (the fixed delay) is computed once, on the first request after reset or
// after any register write. That request passes through the setup states (MUL,
// PREP, LOAD) and the bit-serial restoring divider, then the accumulator step;
// a non-positive divisor skips the divider and saturates the period. Once the
// period is known a request goes straight from accept to the accumulator step,
// which adds into the output register, waiting while it is full and out_ready is low.
// Write registers only
// while no request is in flight.
module fractional_period_divider #(
    parameter int unsigned FRACTION_BITS = fpd_pkg::DEF_FRACTION_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [fpd_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [fpd_pkg::CFG_W-1:0]     cfg_wdata,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          clear_error,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fpd_pkg::WHOLE_W-1:0]   cycle_count,
    output logic                          out_of_range
);

    localparam int unsigned NUM_W = fpd_pkg::CLK_PROD_W + FRACTION_BITS;
    localparam int unsigned DEN_W = fpd_pkg::DEN_W;
    localparam int unsigned PW    = fpd_pkg::PERIOD_W;
    localparam int unsigned WW    = fpd_pkg::WHOLE_W;

    // fixed delay in fraction units, and the quotient above which the period saturates
    localparam logic [NUM_W-1:0] DELAY_Q   = NUM_W'(fpd_pkg::DELAY_CYCLES) << FRACTION_BITS;
    localparam logic [NUM_W-1:0] SAT_LIMIT = NUM_W'(fpd_pkg::I32_MAX) + DELAY_Q;

    fpd_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [fpd_pkg::CLK_W-1:0]   clock_hz_reg, clock_hz_next;
    logic [fpd_pkg::FREQ_W-1:0]  freq_hz_reg, freq_hz_next;
    logic [fpd_pkg::MILLI_W-1:0] milli_reg, milli_next;

    // accumulator state
    logic [PW-1:0] period_reg, period_next;
    logic [PW-1:0] residual_reg, residual_next;
    logic          period_valid_reg, period_valid_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [WW-1:0] out_whole_reg, out_whole_next;
    logic          out_flag_reg, out_flag_next;

    // period setup pipeline
    logic [fpd_pkg::CLK_PROD_W-1:0]  prod_clk_reg, prod_clk_next;
    logic [fpd_pkg::FREQ_PROD_W-1:0] prod_frq_reg, prod_frq_next;
    logic signed [DEN_W:0]           denom_reg, denom_next;

    // divider
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] div_quo;
    logic             div_done;

    // accumulator step
    logic signed [PW:0] diff;
    logic signed [PW:0] whole_s;
    logic               whole_neg;
    logic               whole_big;

    assign div_num = (NUM_W'(prod_clk_reg) << FRACTION_BITS)
                   + NUM_W'(denom_reg[DEN_W-1:1]);

    assign diff      = $signed({period_reg[PW-1], period_reg})
                     - $signed({residual_reg[PW-1], residual_reg});
    assign whole_s   = diff >>> FRACTION_BITS;
    assign whole_neg = whole_s[PW];
    assign whole_big = !whole_neg && (|whole_s[PW-1:WW]);

    always_comb
    begin
        state_next        = state_reg;
        clock_hz_next     = clock_hz_reg;
        freq_hz_next      = freq_hz_reg;
        milli_next        = milli_reg;
        period_next       = period_reg;
        residual_next     = residual_reg;
        period_valid_next = period_valid_reg;
        out_valid_next    = out_valid_reg;
        out_whole_next    = out_whole_reg;
        out_flag_next     = out_flag_reg;
        prod_clk_next     = prod_clk_reg;
        prod_frq_next     = prod_frq_reg;
        denom_next        = denom_reg;
        div_start         = 1'b0;

        // drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fpd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (clear_error)
                    begin
                        residual_next = '0;
                    end
                    state_next = period_valid_reg ? fpd_pkg::ST_CALC : fpd_pkg::ST_MUL;
                end
            end
            fpd_pkg::ST_MUL:
            begin
                // scale both operands; a register follows each product
                prod_clk_next = fpd_pkg::CLK_PROD_W'(clock_hz_reg)
                              * fpd_pkg::CLK_PROD_W'(fpd_pkg::CLK_SCALE);
                prod_frq_next = fpd_pkg::FREQ_PROD_W'(freq_hz_reg)
                              * fpd_pkg::FREQ_PROD_W'(fpd_pkg::FREQ_SCALE);
                state_next    = fpd_pkg::ST_PREP;
            end
            fpd_pkg::ST_PREP:
            begin
                // divisor = 2000*freq_hz + 2*freq_millihz, signed
                denom_next = $signed({{(DEN_W + 1 - fpd_pkg::FREQ_PROD_W){1'b0}}, prod_frq_reg})
                           + $signed({{(DEN_W - fpd_pkg::MILLI_W){milli_reg[fpd_pkg::MILLI_W-1]}},
                                      milli_reg, 1'b0});
                state_next = fpd_pkg::ST_LOAD;
            end
            fpd_pkg::ST_LOAD:
            begin
                if (denom_reg[DEN_W] || (denom_reg == '0))
                begin
                    // non-positive divisor: saturate, skip the divider
                    period_next       = fpd_pkg::I32_MAX;
                    period_valid_next = 1'b1;
                    state_next        = fpd_pkg::ST_CALC;
                end
                else
                begin
                    // numerator carries half the divisor for round-to-nearest
                    div_start  = 1'b1;
                    state_next = fpd_pkg::ST_DIV;
                end
            end
            fpd_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    period_next       = (div_quo > SAT_LIMIT) ? fpd_pkg::I32_MAX
                                                              : PW'(div_quo - DELAY_Q);
                    period_valid_next = 1'b1;
                    state_next        = fpd_pkg::ST_CALC;
                end
            end
            fpd_pkg::ST_CALC:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (whole_neg || whole_big)
                    begin
                        out_whole_next = whole_neg ? '0 : fpd_pkg::WHOLE_MAX;
                        out_flag_next  = 1'b1;
                        residual_next  = '0;
                    end
                    else
                    begin
                        out_whole_next = whole_s[WW-1:0];
                        out_flag_next  = 1'b0;
                        // new error is minus the dropped fraction
                        residual_next  = PW'(0) - PW'(diff[FRACTION_BITS-1:0]);
                    end
                    state_next = fpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpd_pkg::ST_IDLE;
            end
        endcase

        // the user must write registers only while idle (not enforced here); any known index forces a recompute
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fpd_pkg::REG_CLOCK_HZ:
                begin
                    clock_hz_next     = cfg_wdata[fpd_pkg::CLK_W-1:0];
                    period_valid_next = 1'b0;
                end
                fpd_pkg::REG_FREQ_HZ:
                begin
                    freq_hz_next      = cfg_wdata[fpd_pkg::FREQ_W-1:0];
                    period_valid_next = 1'b0;
                end
                fpd_pkg::REG_FREQ_MILLIHZ:
                begin
                    milli_next        = cfg_wdata[fpd_pkg::MILLI_W-1:0];
                    period_valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= fpd_pkg::ST_IDLE;
            clock_hz_reg     <= fpd_pkg::CLK_W'(125000000);
            freq_hz_reg      <= fpd_pkg::FREQ_W'(7000000);
            milli_reg        <= '0;
            period_reg       <= '0;
            residual_reg     <= '0;
            period_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_flag_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clock_hz_reg     <= clock_hz_next;
            freq_hz_reg      <= freq_hz_next;
            milli_reg        <= milli_next;
            period_reg       <= period_next;
            residual_reg     <= residual_next;
            period_valid_reg <= period_valid_next;
            out_valid_reg    <= out_valid_next;
            out_flag_reg     <= out_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_whole_reg <= out_whole_next;
        prod_clk_reg  <= prod_clk_next;
        prod_frq_reg  <= prod_frq_next;
        denom_reg     <= denom_next;
    end

    fpd_serial_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (denom_reg[DEN_W-1:0]),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign in_ready     = (state_reg == fpd_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign cycle_count  = out_whole_reg;
    assign out_of_range = out_flag_reg;

    a_residual_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (residual_reg == '0)
        || ((&residual_reg[PW-1:FRACTION_BITS])
            && (residual_reg[FRACTION_BITS-1:0] != '0)))
        else $error("residual error outside one fraction unit");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_flag_reg)
        |-> ((out_whole_reg == '0) || (out_whole_reg == fpd_pkg::WHOLE_MAX)))
        else $error("clamped result is not at a range limit");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == fpd_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_fast_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && period_valid_reg && !cfg_wr_en)
        |=> (state_reg == fpd_pkg::ST_CALC))
        else $error("known period did not go straight to the step");

endmodule
